>>> rtl/assert_macros.svh
// assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// concurrent assertion with reset disable
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// condition that must never be true out of reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`endif

>>> rtl/gfd_pkg.sv
// ----------------------------------------------------------------------------
// gfd_pkg
// shared types and constants of the goldschmidt divider
// ----------------------------------------------------------------------------
package gfd_pkg;
  localparam int unsigned ROUNDS = 6;
  localparam int unsigned RND_W = $clog2(ROUNDS + 1);
  localparam int unsigned QDEPTH = 2;

  // classified request passed from front to back
  typedef struct packed {
    logic        sign;
    logic        zdiv;
    logic        zdvd;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] d;
    logic [7:0]  e_hi;
    logic [7:0]  e_lo;
  } job_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MX,
    ST_MY,
    ST_DONE
  } bk_state_t;
endpackage

>>> rtl/goldschmidt_float_divider.sv
// ----------------------------------------------------------------------------
// goldschmidt_float_divider
// single-precision division by goldschmidt iteration
// ----------------------------------------------------------------------------
// Usage: drive in_dividend and in_divisor and raise start; the request is
// taken at a rising edge where start is high and busy is low. The front
// stage classifies the operands and places the mantissas; a two-entry queue
// hands classified requests to the back part, which runs the rounds on a
// single shared 32x32 multiplier, one multiply per cycle, two per round.
// out_valid rises once the request has passed the front register, the
// queue, the load of the back part from the queue, the multiplies of all
// ROUNDS rounds and the packing of the result into the output register.
// busy stays high from acceptance through the cycle in which out_valid is
// high, so a new request is taken only after busy has dropped once the
// result is out. out_valid is high for one cycle with the result on
// out_quotient; the receiver cannot stall the block. Reset empties the
// queue and returns the back part to idle; a request in flight at reset
// is dropped and produces no result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module goldschmidt_float_divider (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_dividend,
  input  logic [31:0] in_divisor,
  output logic        out_valid,
  output logic [31:0] out_quotient
);
  gfd_pkg::job_t f_job, q_head;
  logic          f_vld, q_ne, q_full, take, bk_busy, acc, pend_r;

  assign acc = start && !busy;
  // front/queue occupied, back working or result pending
  assign busy = f_vld || q_ne || bk_busy || pend_r;

  // result pending in output register
  always_ff @(posedge clk) begin
    if (!rst_n) pend_r <= 1'b0;
    else pend_r <= bk_busy;
  end

  gfd_front u_front (
    .clk, .rst_n, .in_valid(acc), .in_dividend, .in_divisor,
    .job_valid(f_vld), .job(f_job)
  );

  gfd_queue u_queue (
    .clk, .rst_n, .push(f_vld), .push_data(f_job), .pop(take),
    .not_empty(q_ne), .full(q_full), .head(q_head)
  );

  gfd_back u_back (
    .clk, .rst_n, .job_avail(q_ne), .job(q_head), .job_take(take),
    .busy(bk_busy), .out_valid, .out_quotient
  );

  `ASSERT_NEVER(a_no_push_full, clk, rst_n, f_vld && q_full, "queue overflow")
  `ASSERT_CLK(a_accept_idle, clk, rst_n, acc |=> f_vld, "front did not capture")
  `ASSERT_CLK(a_out_single, clk, rst_n, out_valid |=> !out_valid, "double result")
endmodule

>>> rtl/gfd_front.sv
// ----------------------------------------------------------------------------
// gfd_front
// operand classification, mantissa placement and seed choice
// ----------------------------------------------------------------------------
module gfd_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [31:0]   in_dividend,
  input  logic [31:0]   in_divisor,
  output logic          job_valid,
  output gfd_pkg::job_t job
);
  gfd_pkg::job_t job_r, job_nxt;
  logic          vld_r;
  logic [22:0]   fa, fb;
  logic [7:0]    diff;

  // classify the request
  always_comb begin
    fa = in_dividend[22:0];
    fb = in_divisor[22:0];
    diff = in_dividend[30:23] - in_divisor[30:23];
    job_nxt.sign = in_dividend[31] ^ in_divisor[31];
    job_nxt.zdiv = (in_divisor[30:0] == 31'd0);
    job_nxt.zdvd = (in_dividend[30:0] == 31'd0);
    job_nxt.x = {1'b1, fa, 8'd0};
    if (fb > fa) begin
      job_nxt.y = {2'b01, fb, 7'd0};
      job_nxt.d = in_divisor[22] ? 32'h5000_0000 : 32'h6000_0000;
      job_nxt.e_hi = diff + 8'd126;
      job_nxt.e_lo = diff + 8'd125;
    end else begin
      job_nxt.y = {1'b1, fb, 8'd0};
      job_nxt.d = in_divisor[22] ? 32'h2800_0000 : 32'h3000_0000;
      job_nxt.e_hi = diff + 8'd127;
      job_nxt.e_lo = diff + 8'd126;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_valid;
    end
    if (in_valid) begin
      job_r <= job_nxt;
    end
  end

  assign job_valid = vld_r;
  assign job = job_r;
endmodule

>>> rtl/gfd_queue.sv
// ----------------------------------------------------------------------------
// gfd_queue
// small fifo between the front and back parts
// ----------------------------------------------------------------------------
module gfd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  gfd_pkg::job_t push_data,
  input  logic          pop,
  output logic          not_empty,
  output logic          full,
  output gfd_pkg::job_t head
);
  localparam int unsigned AW = $clog2(gfd_pkg::QDEPTH);
  gfd_pkg::job_t         mem [gfd_pkg::QDEPTH];
  logic [AW-1:0]         wp_r, rp_r;
  logic [AW:0]           cnt_r;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + {{AW{1'b0}}, push} - {{AW{1'b0}}, pop};
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wp_r] <= push_data;
  end

  assign head = mem[rp_r];
  assign not_empty = (cnt_r != '0);
  assign full = (cnt_r == (AW+1)'(gfd_pkg::QDEPTH));
endmodule

>>> rtl/gfd_back.sv
// ----------------------------------------------------------------------------
// gfd_back
// goldschmidt rounds on one shared 32x32 multiplier and result packing
// ----------------------------------------------------------------------------
module gfd_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          job_avail,
  input  gfd_pkg::job_t job,
  output logic          job_take,
  output logic          busy,
  output logic          out_valid,
  output logic [31:0]   out_quotient
);
  gfd_pkg::bk_state_t          st_r, st_nxt;
  gfd_pkg::job_t               j_r;
  logic [31:0]                 x_r, y_r, d_r;
  logic [63:0]                 px_r;
  logic [gfd_pkg::RND_W-1:0]   rnd_r;
  logic [31:0]                 q_r, q_nxt;
  logic                        ov_r;
  logic [31:0]                 mop;
  logic [63:0]                 prod;
  logic [31:0]                 ynew;

  // shared multiplier
  assign mop  = (st_r == gfd_pkg::ST_MX) ? x_r : y_r;
  assign prod = mop * d_r;
  assign ynew = prod[62:31];

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      gfd_pkg::ST_IDLE: if (job_avail) st_nxt = gfd_pkg::ST_MX;
      gfd_pkg::ST_MX:   st_nxt = gfd_pkg::ST_MY;
      gfd_pkg::ST_MY: begin
        if (rnd_r == gfd_pkg::RND_W'(gfd_pkg::ROUNDS - 1)) st_nxt = gfd_pkg::ST_DONE;
        else st_nxt = gfd_pkg::ST_MX;
      end
      gfd_pkg::ST_DONE: st_nxt = gfd_pkg::ST_IDLE;
      default:          st_nxt = gfd_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    job_take = (st_r == gfd_pkg::ST_IDLE) && job_avail;
    busy = (st_r != gfd_pkg::ST_IDLE);
  end

  // result packing
  always_comb begin
    if (j_r.zdiv) begin
      q_nxt = {j_r.sign, 8'hFF, 23'd0};
    end else if (j_r.zdvd) begin
      q_nxt = {j_r.sign, 31'd0};
    end else if (px_r[62]) begin
      q_nxt = {j_r.sign, j_r.e_hi, px_r[61:39]};
    end else begin
      q_nxt = {j_r.sign, j_r.e_lo, px_r[60:38]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= gfd_pkg::ST_IDLE;
      ov_r <= 1'b0;
      rnd_r <= '0;
    end else begin
      st_r <= st_nxt;
      ov_r <= (st_r == gfd_pkg::ST_DONE);
      if (job_take) rnd_r <= '0;
      else if (st_r == gfd_pkg::ST_MY) rnd_r <= rnd_r + 1'b1;
    end
    if (job_take) begin
      j_r <= job;
      x_r <= job.x;
      y_r <= job.y;
      d_r <= job.d;
    end else if (st_r == gfd_pkg::ST_MX) begin
      px_r <= prod;
      x_r  <= prod[62:31];
    end else if (st_r == gfd_pkg::ST_MY) begin
      y_r <= ynew;
      d_r <= ~ynew + 32'd1;
    end
    if (st_r == gfd_pkg::ST_DONE) q_r <= q_nxt;
  end

  assign out_valid = ov_r;
  assign out_quotient = q_r;
endmodule
